@@ hdl/aet_pkg.sv @@
// ----------------------------------------------------------------------------
// aet_pkg: shared types and constants
// Command codes, status codes, FSM states, config defaults and payload structs.
// ----------------------------------------------------------------------------
package aet_pkg;

  typedef enum logic [2:0] {
    CMD_REGISTER = 3'd0,
    CMD_LOOKUP   = 3'd1,
    CMD_DEREG    = 3'd2,
    CMD_COUNT    = 3'd3,
    CMD_TICK     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {S_IDLE, S_PASS1, S_PASS2, S_RESP} state_e;

  localparam logic [0:0] CFG_TTL   = 1'b0;
  localparam logic [0:0] CFG_REAP  = 1'b1;
  localparam logic [15:0] TTL_RESET  = 16'd30;
  localparam logic [15:0] REAP_RESET = 16'd10;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] service_key;
    logic [31:0] endpoint_ip;
    logic [15:0] endpoint_port;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_ip;
    logic [15:0] found_port;
    logic [6:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] stamp;
    logic [31:0] served;
    logic        active;
  } slot_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] key;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] now;
    logic [15:0] ttl;
    logic        reap;
  } ctl_t;

endpackage

@@ hdl/aet_if.sv @@
// ----------------------------------------------------------------------------
// aet_if: valid/ready channels
// Request, response and configuration channels.
// ----------------------------------------------------------------------------
interface aet_req_if;
  logic         valid;
  logic         ready;
  aet_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aet_rsp_if;
  logic         valid;
  logic         ready;
  aet_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aet_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ hdl/aging_endpoint_table_top.sv @@
// ----------------------------------------------------------------------------
// aging_endpoint_table_top: aging endpoint table
// Service endpoint registry with TTL aging and least-served lookup.
// ----------------------------------------------------------------------------
// Usage:
//   req  : command word (register, lookup, deregister, count, tick).
//   rsp  : one response word per request.
//   cfg  : index 0 ttl_seconds, index 1 reap_interval; write while idle.
// The slots sit in a ring of ENTRIES cells that rotates one place a cycle
// while a request is in its passes. Each request takes two full rotations:
// the first finds the target slot (exact match, lowest free slot or
// least-served fresh one), the second applies the update as the slots pass
// the head. One request is handled at a time.
// A stalled response holds in its output register; the next request is
// taken only after the response is delivered.
// Reset clears all valid bits, the seconds clock and the reap counter; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module aging_endpoint_table_top #(
  parameter int ENTRIES = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  aet_req_if.sink  req,
  aet_rsp_if.source rsp,
  aet_cfg_if.sink  cfg
);
  import aet_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  state_e      state_q, state_d;
  logic [IW-1:0] pos_q;
  logic [IW-1:0] pick_q;
  logic        found_q, exact_seen_q, free_seen_q;
  logic [31:0] best_q;
  logic [CW-1:0] cnt_q;
  logic [31:0] clock_q;
  logic [15:0] ticks_q;
  logic [15:0] ttl_q, reap_q;
  ctl_t        ctl_q;
  rsp_t        rsp_q, rsp_d;
  logic [31:0] fip_q;
  logic [15:0] fport_q;

  slot_t chain [ENTRIES+1];
  slot_t head_out;
  logic  fresh, exact, shift;
  logic  last_pos;

  assign shift    = (state_q == S_PASS1) || (state_q == S_PASS2);
  assign last_pos = (pos_q == IW'(ENTRIES - 1));

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    aet_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .slot_i (chain[g+1]),
      .slot_o (chain[g])
    );
  end

  aet_head u_head (
    .ctl_i  (ctl_q),
    .slot_i (chain[0]),
    .pass2_i(state_q == S_PASS2),
    .pick_i (found_q && pos_q == pick_q),
    .fresh_o(fresh),
    .exact_o(exact),
    .slot_o (head_out)
  );
  assign chain[ENTRIES] = head_out;

  assign req.ready = (state_q == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = (state_q == S_RESP);
  assign rsp.data  = rsp_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (req.valid) state_d = S_PASS1;
      S_PASS1: if (last_pos) state_d = S_PASS2;
      S_PASS2: if (last_pos) state_d = S_RESP;
      S_RESP:  if (rsp.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      clock_q <= 32'd0;
      ticks_q <= 16'd0;
      ttl_q   <= TTL_RESET;
      reap_q  <= REAP_RESET;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg.valid) begin
        if (cfg.index == CFG_TTL) ttl_q <= cfg.wdata;
        else reap_q <= cfg.wdata;
      end
      if (shift) pos_q <= last_pos ? '0 : pos_q + IW'(1);
      if (state_q == S_IDLE && req.valid && req.data.command == CMD_TICK) begin
        clock_q <= clock_q + 32'd1;
        if ((ticks_q == 16'hFFFF ? ticks_q : ticks_q + 16'd1) >=
            ((reap_q == 16'd0) ? 16'd1 : reap_q))
          ticks_q <= 16'd0;
        else if (ticks_q != 16'hFFFF)
          ticks_q <= ticks_q + 16'd1;
      end
    end
  end

  logic [15:0] tick_next;
  assign tick_next = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;

  always_comb begin
    rsp_d = '0;
    case (ctl_q.command)
      CMD_REGISTER: if (!found_q) rsp_d.status = ST_FULL;
      CMD_LOOKUP: begin
        if (!found_q) rsp_d.status = ST_NOTFOUND;
        else begin
          rsp_d.found_ip   = (pick_q == pos_q) ? chain[0].ip : fip_q;
          rsp_d.found_port = (pick_q == pos_q) ? chain[0].port : fport_q;
        end
      end
      CMD_DEREG: if (!found_q) rsp_d.status = ST_NOTFOUND;
      CMD_COUNT, CMD_TICK:
        rsp_d.entry_count = (cnt_q > CW'(127)) ? 7'd127 : 7'(cnt_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req.valid) begin
      ctl_q <= '{command: req.data.command,
                 key:     req.data.service_key,
                 ip:      req.data.endpoint_ip,
                 port:    req.data.endpoint_port,
                 now:     (req.data.command == CMD_TICK) ? clock_q + 32'd1 : clock_q,
                 ttl:     ttl_q,
                 reap:    tick_next >= ((reap_q == 16'd0) ? 16'd1 : reap_q)};
      found_q       <= 1'b0;
      exact_seen_q  <= 1'b0;
      free_seen_q   <= 1'b0;
      cnt_q         <= '0;
      pick_q        <= '0;
      best_q        <= '0;
    end
    if (state_q == S_PASS1) begin
      case (ctl_q.command)
        CMD_REGISTER: begin
          if (exact && !exact_seen_q) begin
            exact_seen_q <= 1'b1; found_q <= 1'b1; pick_q <= pos_q;
          end else if (!chain[0].active && !free_seen_q && !exact_seen_q) begin
            free_seen_q <= 1'b1; found_q <= 1'b1; pick_q <= pos_q;
          end
        end
        CMD_LOOKUP: begin
          if (fresh && chain[0].key == ctl_q.key &&
              (!found_q || chain[0].served < best_q)) begin
            found_q <= 1'b1; pick_q <= pos_q; best_q <= chain[0].served;
          end
        end
        CMD_DEREG: begin
          if (exact && !found_q) begin
            found_q <= 1'b1; pick_q <= pos_q;
          end
        end
        CMD_COUNT: if (fresh) cnt_q <= cnt_q + CW'(1);
        CMD_TICK:  if (ctl_q.reap && chain[0].active && !fresh) cnt_q <= cnt_q + CW'(1);
        default: ;
      endcase
    end
    if (state_q == S_PASS2 && found_q && pos_q == pick_q) begin
      fip_q   <= chain[0].ip;
      fport_q <= chain[0].port;
    end
    if (state_q == S_PASS2 && last_pos) begin
      rsp_q <= rsp_d;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> !rsp.valid) else $error("ready while response pending");
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("response dropped");
  a_pass_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PASS1) && last_pos |=> (state_q == S_PASS2) && pos_q == '0)
    else $error("pass misaligned");
endmodule

@@ hdl/aet_cell.sv @@
// ----------------------------------------------------------------------------
// aet_cell: one table slot
// Holds one entry and passes it to the next cell each rotation cycle.
// ----------------------------------------------------------------------------
module aet_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  aet_pkg::slot_t slot_i,
  output aet_pkg::slot_t slot_o
);
  import aet_pkg::*;

  slot_t slot_q;
  logic  act_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      slot_q <= slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (shift_i) begin
      act_q <= slot_i.active;
    end
  end

  always_comb begin
    slot_o        = slot_q;
    slot_o.active = act_q;
  end
endmodule

@@ hdl/aet_head.sv @@
// ----------------------------------------------------------------------------
// aet_head: chain head processing
// Inspects the slot leaving the chain on each pass and rewrites it on the second.
// ----------------------------------------------------------------------------
module aet_head (
  input  aet_pkg::ctl_t  ctl_i,
  input  aet_pkg::slot_t slot_i,
  input  logic           pass2_i,
  input  logic           pick_i,
  output logic           fresh_o,
  output logic           exact_o,
  output aet_pkg::slot_t slot_o
);
  import aet_pkg::*;

  logic [31:0] age;

  always_comb begin
    age     = ctl_i.now - slot_i.stamp;
    fresh_o = slot_i.active && (age < {16'd0, ctl_i.ttl});
    exact_o = slot_i.active && slot_i.key == ctl_i.key && slot_i.ip == ctl_i.ip &&
              slot_i.port == ctl_i.port;
    slot_o  = slot_i;
    if (pass2_i && pick_i) begin
      case (ctl_i.command)
        CMD_REGISTER: begin
          if (!slot_i.active) begin
            slot_o.key    = ctl_i.key;
            slot_o.ip     = ctl_i.ip;
            slot_o.port   = ctl_i.port;
            slot_o.served = 32'd0;
            slot_o.active = 1'b1;
          end
          slot_o.stamp = ctl_i.now;
        end
        CMD_LOOKUP: begin
          if (slot_i.served != 32'hFFFF_FFFF) slot_o.served = slot_i.served + 32'd1;
        end
        CMD_DEREG: slot_o.active = 1'b0;
        default: ;
      endcase
    end
    if (pass2_i && ctl_i.command == CMD_TICK && ctl_i.reap && slot_i.active && !fresh_o) begin
      slot_o.active = 1'b0;
    end
  end
endmodule
